/* rtl/core/srvpwm_pkg.sv */
// ----------------------------------------------------------------------------
// Servo PWM package
// Shared types, codes, constants and the channel-to-timer-group map.
// ----------------------------------------------------------------------------
package srvpwm_pkg;

    localparam int NUM_PINS   = 11;
    localparam int NUM_GROUPS = 4;
    localparam int NUM_TOPS   = 3;

    // Timer ticks per second at half-microsecond resolution.
    localparam logic [20:0] TICKS_PER_SECOND = 21'd2000000;
    localparam int          DIV_STEPS        = 21;

    localparam logic [15:0] TOP_RESET     = 16'd40000;
    localparam logic [15:0] COMPARE_RESET = 16'hFFFF;
    localparam logic [14:0] MIN_RESET     = 15'd900;
    localparam logic [14:0] MAX_RESET     = 15'd2100;

    // Channel mask bits that select each timer group for a frequency change.
    localparam logic [10:0] GROUP0_BITS = 11'h003;
    localparam logic [10:0] GROUP1_BITS = 11'h01C;
    localparam logic [10:0] GROUP2_BITS = 11'h0E0;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_ENABLE,
        OP_DISABLE,
        OP_SET_FREQ,
        OP_GET_FREQ,
        OP_TICK,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        CFG_MIN_PULSE,
        CFG_MAX_PULSE,
        CFG_SHARED_TOP
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } t_div_rsp;

    // True for channels that drive an output pin.
    function automatic logic chan_ok(input logic [3:0] ch);
        logic ok;
        unique case (ch)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd10: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Timer group of a channel; meaningful only where chan_ok is true.
    function automatic logic [1:0] chan_grp(input logic [3:0] ch);
        logic [1:0] grp;
        unique case (ch)
            4'd0, 4'd1:       grp = 2'd0;
            4'd2, 4'd3, 4'd4: grp = 2'd1;
            4'd5, 4'd6, 4'd7: grp = 2'd2;
            default:          grp = 2'd3;
        endcase
        return grp;
    endfunction

endpackage

/* rtl/core/srvpwm_if.sv */
// ----------------------------------------------------------------------------
// Servo PWM channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface srvpwm_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [3:0]  channel;
    logic [15:0] pulse_us;
    logic [10:0] channel_mask;
    logic [15:0] freq_hz;

    modport source (output valid, operation, channel, pulse_us, channel_mask, freq_hz,
                    input ready);
    modport sink   (input valid, operation, channel, pulse_us, channel_mask, freq_hz,
                    output ready);
endinterface

interface srvpwm_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic [10:0] pin_levels;
    logic        bad_request;

    modport source (output valid, read_value, pin_levels, bad_request, input ready);
    modport sink   (input valid, read_value, pin_levels, bad_request, output ready);
endinterface

interface srvpwm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/srvpwm_div.sv */
// ----------------------------------------------------------------------------
// Servo PWM serial divider
// Restoring divider that forms the tick rate divided by a 16-bit value,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srvpwm_div import srvpwm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [20:0] r_quo;
    logic [15:0] r_div;

    logic [16:0] w_trial;
    logic [15:0] w_diff;
    logic        w_fit;
    logic [15:0] n_rem;

    // When the trial fits, the difference is below the divisor, so its low
    // 16 bits are the whole remainder.
    always_comb begin
        w_trial = {r_rem, r_quo[20]};
        w_diff  = w_trial[15:0] - r_div;
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_diff : w_trial[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 5'd1;
                r_busy <= (r_cnt != 5'(DIV_STEPS - 1));
                r_done <= (r_cnt == 5'(DIV_STEPS - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // The dividend shifts out of the top of the quotient register as the
    // quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= TICKS_PER_SECOND;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[19:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[15:0];

endmodule

/* rtl/core/srvpwm_pins.sv */
// ----------------------------------------------------------------------------
// Servo PWM pin compare
// Evaluates every output pin level from its compare value, group counter,
// group top and enable bit.
// ----------------------------------------------------------------------------
module srvpwm_pins import srvpwm_pkg::*; #(
    parameter int CHANNEL_SLOTS = 11
) (
    input  logic [15:0]         i_cmp     [CHANNEL_SLOTS],
    input  logic [15:0]         i_top     [NUM_GROUPS],
    input  logic [15:0]         i_counter [NUM_GROUPS],
    input  logic [NUM_PINS-1:0] i_en,
    output logic [NUM_PINS-1:0] o_levels
);

    for (genvar gi = 0; gi < NUM_PINS; gi++) begin : g_pin
        if (gi < CHANNEL_SLOTS && chan_ok(4'(gi))) begin : g_live
            localparam logic [1:0] GRP = chan_grp(4'(gi));
            // A compare value above the group top keeps the pin low.
            assign o_levels[gi] = i_en[gi]
                                  && (i_cmp[gi] <= i_top[GRP])
                                  && (i_counter[GRP] < i_cmp[gi]);
        end else begin : g_dead
            assign o_levels[gi] = 1'b0;
        end
    end

endmodule

/* rtl/core/multichannel_servo_pwm_output_top.sv */
// ----------------------------------------------------------------------------
// Multichannel servo PWM output
// Eleven-channel servo pulse generator in four timer groups, driven by
// write/read/enable/frequency/tick requests, with one response per request.
// ----------------------------------------------------------------------------
// Most requests go through the execute and finish states to the output;
// a set-freq or get-freq that needs a division also runs the 21-step divider.
// Requests are taken one at a time; the next one is taken once the response
// is loaded into the output register, which waits for that register to free.
// Reset: synchronous, active low; restores state, config and output valid.
module multichannel_servo_pwm_output_top import srvpwm_pkg::*; #(
    parameter int CHANNEL_SLOTS = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srvpwm_req_if.sink    i_req,
    srvpwm_cfg_if.sink    i_cfg,
    srvpwm_rsp_if.source  o_rsp
);

    t_state r_state, n_state;

    // Request being worked on.
    t_op         r_op;
    logic [3:0]  r_ch;
    logic [15:0] r_pulse;
    logic [10:0] r_mask;
    logic [15:0] r_freq;
    logic [15:0] r_value;
    logic        r_bad;

    // Configuration and block state.
    logic [14:0]         r_min;
    logic [14:0]         r_max;
    logic [15:0]         r_shared_top;
    logic [15:0]         r_group_top [NUM_TOPS];
    logic [15:0]         r_counter   [NUM_GROUPS];
    logic [15:0]         r_cmp       [CHANNEL_SLOTS];
    logic [NUM_PINS-1:0] r_en;

    // Output register.
    logic                r_out_valid;
    logic [15:0]         r_out_value;
    logic [NUM_PINS-1:0] r_out_pins;
    logic                r_out_bad;

    logic [15:0]         w_top [NUM_GROUPS];
    logic [NUM_PINS-1:0] w_vmask;
    logic [NUM_PINS-1:0] w_pins;
    logic                w_sel_ok;
    logic [15:0]         w_sel_top;
    logic [15:0]         w_cmp_rd;
    logic [14:0]         w_clamped;
    logic                w_div_need;
    logic                w_fin_load;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    always_comb begin
        for (int g = 0; g < NUM_TOPS; g++) begin
            w_top[g] = r_group_top[g];
        end
        w_top[NUM_GROUPS-1] = r_shared_top;

        for (int i = 0; i < NUM_PINS; i++) begin
            w_vmask[i] = (i < CHANNEL_SLOTS) && chan_ok(4'(i));
        end

        w_sel_ok  = chan_ok(r_ch) && ({1'b0, r_ch} < 5'(CHANNEL_SLOTS));
        w_sel_top = w_top[chan_grp(r_ch)];

        w_cmp_rd = '0;
        for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            if (r_ch == 4'(i)) begin
                w_cmp_rd = r_cmp[i];
            end
        end

        // The maximum is tested before the minimum.
        priority if (r_pulse > {1'b0, r_max}) begin
            w_clamped = r_max;
        end else if (r_pulse < {1'b0, r_min}) begin
            w_clamped = r_min;
        end else begin
            w_clamped = r_pulse[14:0];
        end

        w_div_need = ((r_op == OP_SET_FREQ) && (r_freq != '0))
                     || ((r_op == OP_GET_FREQ) && w_sel_ok && (w_sel_top != '0));
    end

    // Sequencer.
    always_comb begin
        n_state           = r_state;
        w_div_req.start   = 1'b0;
        w_div_req.divisor = (r_op == OP_SET_FREQ) ? r_freq : w_sel_top;
        w_fin_load        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_div_need) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_fin_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture and per-request results.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_op    <= t_op'(i_req.operation);
            r_ch    <= i_req.channel;
            r_pulse <= i_req.pulse_us;
            r_mask  <= i_req.channel_mask;
            r_freq  <= i_req.freq_hz;
        end
        if (r_state == S_EXEC) begin
            unique case (r_op)
                OP_WRITE, OP_READ, OP_GET_FREQ: begin
                    r_bad   <= !w_sel_ok;
                    r_value <= (w_sel_ok && r_op == OP_READ) ? {1'b0, w_cmp_rd[15:1]}
                                                             : 16'd0;
                end
                OP_SET_FREQ: begin
                    r_bad   <= (r_freq == '0);
                    r_value <= '0;
                end
                OP_ENABLE, OP_DISABLE, OP_TICK, OP_NOP: begin
                    r_bad   <= 1'b0;
                    r_value <= '0;
                end
            endcase
        end else if (r_state == S_DIV && w_div_rsp.done && r_op == OP_GET_FREQ) begin
            r_value <= w_div_rsp.quotient;
        end
    end

    // Block state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min        <= MIN_RESET;
            r_max        <= MAX_RESET;
            r_shared_top <= TOP_RESET;
            r_en         <= '0;
            for (int g = 0; g < NUM_TOPS; g++) begin
                r_group_top[g] <= TOP_RESET;
            end
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_counter[g] <= '0;
            end
            for (int i = 0; i < CHANNEL_SLOTS; i++) begin
                r_cmp[i] <= COMPARE_RESET;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    CFG_MIN_PULSE:  r_min        <= i_cfg.data[14:0];
                    CFG_MAX_PULSE:  r_max        <= i_cfg.data[14:0];
                    CFG_SHARED_TOP: r_shared_top <= i_cfg.data;
                    default: begin
                    end
                endcase
            end

            if (r_state == S_EXEC) begin
                unique case (r_op)
                    OP_WRITE: begin
                        for (int i = 0; i < CHANNEL_SLOTS; i++) begin
                            if (w_sel_ok && r_ch == 4'(i)) begin
                                r_cmp[i] <= {w_clamped, 1'b0};
                            end
                        end
                    end
                    OP_ENABLE:  r_en <= r_en | (r_mask & w_vmask);
                    OP_DISABLE: r_en <= r_en & ~(r_mask & w_vmask);
                    OP_TICK: begin
                        for (int g = 0; g < NUM_GROUPS; g++) begin
                            if (r_counter[g] >= w_top[g]) begin
                                r_counter[g] <= '0;
                            end else begin
                                r_counter[g] <= r_counter[g] + 16'd1;
                            end
                        end
                    end
                    OP_READ, OP_SET_FREQ, OP_GET_FREQ, OP_NOP: begin
                    end
                endcase
            end

            // Mask bits of the shared group select no top.
            if (r_state == S_DIV && w_div_rsp.done && r_op == OP_SET_FREQ) begin
                if ((r_mask & GROUP0_BITS) != '0) r_group_top[0] <= w_div_rsp.quotient;
                if ((r_mask & GROUP1_BITS) != '0) r_group_top[1] <= w_div_rsp.quotient;
                if ((r_mask & GROUP2_BITS) != '0) r_group_top[2] <= w_div_rsp.quotient;
            end
        end
    end

    // Output register; the pin levels reflect the state after the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_value <= r_value;
            r_out_pins  <= w_pins;
            r_out_bad   <= r_bad;
        end
    end

    srvpwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    srvpwm_pins #(
        .CHANNEL_SLOTS (CHANNEL_SLOTS)
    ) u_pins (
        .i_cmp     (r_cmp),
        .i_top     (w_top),
        .i_counter (r_counter),
        .i_en      (r_en),
        .o_levels  (w_pins)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.pin_levels  = r_out_pins;
    assign o_rsp.bad_request = r_out_bad;

endmodule

/* rtl/core/srvpwm_chk.sv */
// ----------------------------------------------------------------------------
// Servo PWM port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module srvpwm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] rsp_read_value,
    input logic [10:0] rsp_pin_levels,
    input logic        rsp_bad_request
);

    // The block works on one request at a time.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a request is in progress");

    a_bad_has_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_bad_request |-> rsp_read_value == 16'd0)
        else $error("rejected request returned a nonzero value");

    // Channel 8 has no output.
    a_pin8_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !rsp_pin_levels[8])
        else $error("unused channel pin driven high");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
        else $error("stalled response changed");

endmodule

bind multichannel_servo_pwm_output_top srvpwm_chk u_srvpwm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .req_valid       (i_req.valid),
    .req_ready       (i_req.ready),
    .rsp_valid       (o_rsp.valid),
    .rsp_ready       (o_rsp.ready),
    .rsp_read_value  (o_rsp.read_value),
    .rsp_pin_levels  (o_rsp.pin_levels),
    .rsp_bad_request (o_rsp.bad_request)
);
